// ----- hw/rtl/prd_pkg.sv -----
// Shared types and constants for the pinhole camera ray direction block.
// No dependencies.
package prd_pkg;

    localparam int NRM_BITS   = 30;
    localparam int SQ_BITS    = 2 * NRM_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int ROOT_STEPS = 32;
    localparam int RT_BITS    = 2 * ROOT_STEPS - 1;
    localparam int LEN_BITS   = 32;
    localparam int FRAC_OUT   = 14;
    localparam int QUO_BITS   = FRAC_OUT + 1;
    localparam int REM_BITS   = NRM_BITS + FRAC_OUT + 2;
    localparam int OUT_BITS   = 16;
    localparam int SCALE_BITS = 16;
    localparam int CFG_BITS   = 64;

    localparam logic [QUO_BITS-1:0]   UNIT_OUT  = QUO_BITS'(1) << FRAC_OUT;
    localparam logic [SCALE_BITS-1:0] SCALE_RST = 16'd4096;

    typedef enum logic [2:0] {
        REG_FWD   = 3'd0,
        REG_RIGHT = 3'd1,
        REG_UP    = 3'd2,
        REG_HSCL  = 3'd3,
        REG_VSCL  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic                         zero;
        logic [2:0]                   neg;
        logic [2:0][NRM_BITS-1:0]     mag;
    } t_side;

endpackage

// ----- hw/rtl/perspective_ray_direction.sv -----
// Pinhole camera ray direction: screen (u, v) in, unit direction vector out.
// Depends on prd_pkg (stage bundle type, register indexes, constants).
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+---------------------------------
//  request  | start, busy (always low)      | i_screen_u, i_screen_v
//  result   | o_done, one cycle             | o_dir_x, o_dir_y, o_dir_z
//  config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One request per cycle; each request passes the front stages, the 32-stage square
// root, the 15-stage divider and the output register before its result is shown.
// Synchronous active-low reset clears the valid chain and loads the configuration registers with their defaults.
// Results cannot be stalled, so the pipeline never holds.
module perspective_ray_direction #(
    parameter int COORD_BITS = 16,
    parameter int AXIS_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [COORD_BITS-1:0]               i_screen_u,
    input  logic [COORD_BITS-1:0]               i_screen_v,
    output logic                                o_done,
    output logic signed [prd_pkg::OUT_BITS-1:0] o_dir_x,
    output logic signed [prd_pkg::OUT_BITS-1:0] o_dir_y,
    output logic signed [prd_pkg::OUT_BITS-1:0] o_dir_z,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [5:0]                          paddr,
    input  logic [prd_pkg::CFG_BITS-1:0]        pwdata,
    output logic [prd_pkg::CFG_BITS-1:0]        prdata,
    output logic                                pready
);
    import prd_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int A    = AXIS_BITS;
    localparam int EXTW = 3 * A + CFG_BITS;
    localparam int PW   = C + 20;
    localparam int XW   = 22;
    localparam int MPW  = XW + A;
    localparam int CW   = XW + A + 2;
    localparam int MW   = CW - 1;
    localparam int NBW  = $clog2(MW + 1);
    localparam int LAT  = 10 + ROOT_STEPS + QUO_BITS + 1;

    localparam logic [127:0] FWD_W = (128'(3) << (A - 2)) << (2 * A);
    localparam logic [127:0] UP_W  = (128'(1) << (A - 2)) << A;
    localparam logic [127:0] RGT_W = 128'(1) << (A - 2);

    // configuration
    logic [CFG_BITS-1:0]   r_fwd, r_rgt, r_up;
    logic [SCALE_BITS-1:0] r_hs, r_vs;

    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= FWD_W[CFG_BITS-1:0];
            r_rgt <= RGT_W[CFG_BITS-1:0];
            r_up  <= UP_W[CFG_BITS-1:0];
            r_hs  <= SCALE_RST;
            r_vs  <= SCALE_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (t_reg_idx'(paddr[5:3]))
                REG_FWD:   r_fwd <= pwdata;
                REG_RIGHT: r_rgt <= pwdata;
                REG_UP:    r_up  <= pwdata;
                REG_HSCL:  r_hs  <= pwdata[SCALE_BITS-1:0];
                REG_VSCL:  r_vs  <= pwdata[SCALE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[5:3]))
            REG_FWD:   prdata = r_fwd;
            REG_RIGHT: prdata = r_rgt;
            REG_UP:    prdata = r_up;
            REG_HSCL:  prdata = CFG_BITS'(r_hs);
            REG_VSCL:  prdata = CFG_BITS'(r_vs);
            default:   prdata = '0;
        endcase
    end

    logic [EXTW-1:0]      w_fext, w_rext, w_uext;
    logic signed [A-1:0]  w_f [3];
    logic signed [A-1:0]  w_r [3];
    logic signed [A-1:0]  w_u [3];

    assign w_fext = EXTW'(r_fwd);
    assign w_rext = EXTW'(r_rgt);
    assign w_uext = EXTW'(r_up);

    for (genvar i = 0; i < 3; i++) begin : g_axis
        assign w_f[i] = $signed(w_fext[i*A +: A]);
        assign w_r[i] = $signed(w_rext[i*A +: A]);
        assign w_u[i] = $signed(w_uext[i*A +: A]);
    end

    // valid chain
    logic [LAT:1] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-1:1], start && !busy};
        end
    end

    // stage 1: capture request
    logic [C-1:0] r1_u, r1_v;
    always_ff @(posedge i_clk) begin
        r1_u <= i_screen_u;
        r1_v <= i_screen_v;
    end

    // stage 2: scale products
    localparam logic [C+2:0] ONE_C = (C+3)'(1) << C;
    logic signed [C+2:0] w_su, w_sv;
    logic signed [PW-1:0] r2_px, r2_py;
    assign w_su = $signed({2'b00, r1_u, 1'b0} - ONE_C);
    assign w_sv = $signed(ONE_C - {2'b00, r1_v, 1'b0});
    always_ff @(posedge i_clk) begin
        r2_px <= w_su * $signed({1'b0, r_hs});
        r2_py <= w_sv * $signed({1'b0, r_vs});
    end

    // stage 3: round to Q.16, ties away from zero
    logic [PW-1:0] w_pxm, w_pym, w_rx, w_ry;
    logic signed [XW-1:0] r3_x, r3_y;
    always_comb begin
        w_pxm = r2_px[PW-1] ? PW'(-r2_px) : PW'(r2_px);
        w_pym = r2_py[PW-1] ? PW'(-r2_py) : PW'(r2_py);
        w_rx  = (w_pxm + (PW'(1) << (C - 5))) >> (C - 4);
        w_ry  = (w_pym + (PW'(1) << (C - 5))) >> (C - 4);
    end
    always_ff @(posedge i_clk) begin
        r3_x <= r2_px[PW-1] ? -$signed(w_rx[XW-1:0]) : $signed(w_rx[XW-1:0]);
        r3_y <= r2_py[PW-1] ? -$signed(w_ry[XW-1:0]) : $signed(w_ry[XW-1:0]);
    end

    // stage 4: basis products; stage 5: sum and magnitude
    logic signed [MPW-1:0] r4_pr [3];
    logic signed [MPW-1:0] r4_pu [3];
    logic signed [CW-1:0]  w_c   [3];
    logic [MW-1:0]         r5_mag [3];
    logic [2:0]            r5_neg;
    for (genvar i = 0; i < 3; i++) begin : g_lane
        always_ff @(posedge i_clk) begin
            r4_pr[i] <= r3_x * w_r[i];
            r4_pu[i] <= r3_y * w_u[i];
        end
        assign w_c[i] = CW'(r4_pr[i]) - CW'(r4_pu[i]) + (CW'(w_f[i]) <<< 16);
        always_ff @(posedge i_clk) begin
            r5_neg[i] <= w_c[i][CW-1];
            r5_mag[i] <= w_c[i][CW-1] ? MW'(-w_c[i]) : MW'(w_c[i]);
        end
    end

    // stage 6: merge for leading one; stage 7: bit count; stage 8: normalize
    logic [MW-1:0]  r6_or, r6_mag [3], r7_mag [3];
    logic [2:0]     r6_neg, r7_neg;
    logic [NBW-1:0] w_nb, r7_nb;
    logic           r7_zero;
    t_side          r8_sd;
    logic [MW-1:0]  w_sh [3];

    always_ff @(posedge i_clk) begin
        r6_or  <= r5_mag[0] | r5_mag[1] | r5_mag[2];
        r6_mag <= r5_mag;
        r6_neg <= r5_neg;
    end

    always_comb begin
        w_nb = '0;
        for (int j = 0; j < MW; j++) begin
            if (r6_or[j]) w_nb = NBW'(j + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        r7_nb   <= w_nb;
        r7_zero <= (r6_or == '0);
        r7_mag  <= r6_mag;
        r7_neg  <= r6_neg;
    end

    for (genvar i = 0; i < 3; i++) begin : g_norm
        assign w_sh[i] = (r7_nb > NBW'(NRM_BITS)) ? (r7_mag[i] >> (r7_nb - NBW'(NRM_BITS)))
                                                  : (r7_mag[i] << (NBW'(NRM_BITS) - r7_nb));
        always_ff @(posedge i_clk) begin
            r8_sd.mag[i] <= w_sh[i][NRM_BITS-1:0];
        end
    end
    always_ff @(posedge i_clk) begin
        r8_sd.neg  <= r7_neg;
        r8_sd.zero <= r7_zero;
    end

    // stage 9: squares; stage 10: sum of squares
    logic [SQ_BITS-1:0]  r9_sq [3];
    t_side               r9_sd, r10_sd;
    logic [SUM_BITS-1:0] r10_s;
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r9_sq[i] <= r8_sd.mag[i] * r8_sd.mag[i];
        end
        r9_sd  <= r8_sd;
        r10_s  <= SUM_BITS'(r9_sq[0]) + SUM_BITS'(r9_sq[1]) + SUM_BITS'(r9_sq[2]);
        r10_sd <= r9_sd;
    end

    // integer square root, two bits per stage
    logic [RT_BITS-1:0] r_qs_s   [ROOT_STEPS];
    logic [RT_BITS-1:0] r_qs_res [ROOT_STEPS];
    t_side              r_qs_sd  [ROOT_STEPS];

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        localparam logic [RT_BITS-1:0] BIT = RT_BITS'(1) << (RT_BITS - 1 - 2 * k);
        logic [RT_BITS-1:0] w_s, w_res, w_try;
        t_side              w_sd;
        if (k == 0) begin : g_first
            assign w_s   = RT_BITS'(r10_s);
            assign w_res = '0;
            assign w_sd  = r10_sd;
        end else begin : g_next
            assign w_s   = r_qs_s[k-1];
            assign w_res = r_qs_res[k-1];
            assign w_sd  = r_qs_sd[k-1];
        end
        assign w_try = w_res + BIT;
        always_ff @(posedge i_clk) begin
            if (w_s >= w_try) begin
                r_qs_s[k]   <= w_s - w_try;
                r_qs_res[k] <= (w_res >> 1) + BIT;
            end else begin
                r_qs_s[k]   <= w_s;
                r_qs_res[k] <= w_res >> 1;
            end
            r_qs_sd[k] <= w_sd;
        end
    end

    // restoring division, one quotient bit per stage
    logic [REM_BITS-1:0] r_dv_rem [QUO_BITS][3];
    logic [QUO_BITS-1:0] r_dv_q   [QUO_BITS][3];
    logic [LEN_BITS-1:0] r_dv_len [QUO_BITS];
    t_side               r_dv_sd  [QUO_BITS];

    for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
        localparam int K = QUO_BITS - 1 - j;
        logic [LEN_BITS-1:0] w_len;
        logic [REM_BITS-1:0] w_d;
        t_side               w_sd;
        if (j == 0) begin : g_first
            assign w_len = r_qs_res[ROOT_STEPS-1][LEN_BITS-1:0];
            assign w_sd  = r_qs_sd[ROOT_STEPS-1];
        end else begin : g_next
            assign w_len = r_dv_len[j-1];
            assign w_sd  = r_dv_sd[j-1];
        end
        assign w_d = REM_BITS'(w_len) << K;
        for (genvar i = 0; i < 3; i++) begin : g_dl
            logic [REM_BITS-1:0] w_rem;
            logic [QUO_BITS-1:0] w_q;
            if (j == 0) begin : g_first
                assign w_rem = (REM_BITS'(w_sd.mag[i]) << FRAC_OUT) + REM_BITS'(w_len >> 1);
                assign w_q   = '0;
            end else begin : g_next
                assign w_rem = r_dv_rem[j-1][i];
                assign w_q   = r_dv_q[j-1][i];
            end
            always_ff @(posedge i_clk) begin
                if (w_rem >= w_d) begin
                    r_dv_rem[j][i] <= w_rem - w_d;
                    r_dv_q[j][i]   <= w_q | (QUO_BITS'(1) << K);
                end else begin
                    r_dv_rem[j][i] <= w_rem;
                    r_dv_q[j][i]   <= w_q;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_dv_len[j] <= w_len;
            r_dv_sd[j]  <= w_sd;
        end
    end

    // output stage: clamp, sign, zero vector
    logic [OUT_BITS-1:0] w_o [3];
    t_side               w_fsd;
    assign w_fsd = r_dv_sd[QUO_BITS-1];
    for (genvar i = 0; i < 3; i++) begin : g_out
        logic [QUO_BITS-1:0] w_clp;
        assign w_clp = w_fsd.zero ? '0 :
                       (r_dv_q[QUO_BITS-1][i] > UNIT_OUT) ? UNIT_OUT : r_dv_q[QUO_BITS-1][i];
        assign w_o[i] = w_fsd.neg[i] ? OUT_BITS'(-OUT_BITS'(w_clp)) : OUT_BITS'(w_clp);
    end

    logic signed [OUT_BITS-1:0] r_ox, r_oy, r_oz;
    always_ff @(posedge i_clk) begin
        r_ox <= $signed(w_o[0]);
        r_oy <= $signed(w_o[1]);
        r_oz <= $signed(w_o[2]);
    end

    assign o_done  = r_vld[LAT];
    assign o_dir_x = r_ox;
    assign o_dir_y = r_oy;
    assign o_dir_z = r_oz;

`ifndef SYNTH
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("request did not produce a result");
    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result without a request");
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_dir_x <= 16'sd16384 && o_dir_x >= -16'sd16384 &&
                    o_dir_y <= 16'sd16384 && o_dir_y >= -16'sd16384 &&
                    o_dir_z <= 16'sd16384 && o_dir_z >= -16'sd16384))
        else $error("direction component outside unit range");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the pinhole camera ray direction block.
// Depends on prd_pkg and perspective_ray_direction; drives requests and APB writes.
`timescale 1ns / 100ps

module testbench;
    import prd_pkg::*;

    localparam int DRAIN_CYCLES = 64;
    localparam int BAD_IDX      = 5;

    typedef struct {
        logic signed [OUT_BITS-1:0] x;
        logic signed [OUT_BITS-1:0] y;
        logic signed [OUT_BITS-1:0] z;
    } t_dir;

    typedef struct {
        logic [15:0] u;
        logic [15:0] v;
        bit          typed;
        t_dir        dir;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [15:0]            i_screen_u = '0;
    logic [15:0]            i_screen_v = '0;
    logic                   o_done;
    logic signed [15:0]     o_dir_x, o_dir_y, o_dir_z;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [5:0]             paddr = '0;
    logic [CFG_BITS-1:0]    pwdata = '0;
    logic [CFG_BITS-1:0]    prdata;
    logic                   pready;

    logic [63:0] fwd_axis, right_axis, up_axis;
    logic [15:0] h_scale, v_scale;

    t_dir   dir_queue[$];
    t_dir   typed_queue[$];
    bit     typed_flags[$];
    int     errors = 0;

    perspective_ray_direction uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_screen_u(i_screen_u), .i_screen_v(i_screen_v),
        .o_done(o_done), .o_dir_x(o_dir_x), .o_dir_y(o_dir_y), .o_dir_z(o_dir_z),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint axis_comp(logic [63:0] r, int i);
        logic signed [15:0] c;
        c = r[16*i +: 16];
        return longint'(c);
    endfunction

    function automatic longint round_q16(longint p);
        longint unsigned m;
        m = (p < 0) ? longint'(-p) : p;
        m = (m + 64'd2048) >> 12;
        return (p < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_dir ray_dir(logic [15:0] u, logic [15:0] v);
        longint          x, y, c;
        longint unsigned mag[3], m, s, len, r;
        bit              neg[3];
        int              nb;
        logic [15:0]     o[3];
        t_dir            d;
        x = round_q16((2 * longint'(u) - 65536) * longint'(h_scale));
        y = round_q16((65536 - 2 * longint'(v)) * longint'(v_scale));
        m = 0;
        for (int i = 0; i < 3; i++) begin
            c = x * axis_comp(right_axis, i) - y * axis_comp(up_axis, i)
                + axis_comp(fwd_axis, i) * 65536;
            neg[i] = c < 0;
            mag[i] = neg[i] ? longint'(-c) : c;
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            d.x = '0; d.y = '0; d.z = '0;
            return d;
        end
        nb = 0;
        while (m != 0) begin
            nb++;
            m = m >> 1;
        end
        for (int i = 0; i < 3; i++)
            mag[i] = (nb > NRM_BITS) ? mag[i] >> (nb - NRM_BITS) : mag[i] << (NRM_BITS - nb);
        s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            r = ((mag[i] << FRAC_OUT) + (len >> 1)) / len;
            if (r > 16384) r = 16384;
            if (neg[i]) r = -r;
            o[i] = r[15:0];
        end
        d.x = o[0]; d.y = o[1]; d.z = o[2];
        return d;
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what,
                 $signed(got), $signed(want), $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_dir want;
        if (i_rst_n && start && !busy)
            dir_queue.push_back(ray_dir(i_screen_u, i_screen_v));
        if (i_rst_n && o_done) begin
            if (dir_queue.size() == 0) begin
                report("unexpected result", o_dir_x, 16'd0);
            end else begin
                want = dir_queue.pop_front();
                if (o_dir_x !== want.x) report("dir_x", o_dir_x, want.x);
                if (o_dir_y !== want.y) report("dir_y", o_dir_y, want.y);
                if (o_dir_z !== want.z) report("dir_z", o_dir_z, want.z);
                if (typed_flags.size() > 0) begin
                    if (typed_flags.pop_front()) begin
                        want = typed_queue.pop_front();
                        if (o_dir_x !== want.x) report("table dir_x", o_dir_x, want.x);
                        if (o_dir_y !== want.y) report("table dir_y", o_dir_y, want.y);
                        if (o_dir_z !== want.z) report("table dir_z", o_dir_z, want.z);
                    end
                end
            end
        end
    end

    task automatic cfg_write(int idx, logic [63:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx * 8);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FWD:   fwd_axis   = val;
            REG_RIGHT: right_axis = val;
            REG_UP:    up_axis    = val;
            REG_HSCL:  h_scale    = val[15:0];
            REG_VSCL:  v_scale    = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_camera(logic [63:0] f, logic [63:0] r, logic [63:0] up,
                              logic [63:0] hs, logic [63:0] vs);
        cfg_write(REG_FWD, f);
        cfg_write(REG_RIGHT, r);
        cfg_write(REG_UP, up);
        cfg_write(REG_HSCL, hs);
        cfg_write(REG_VSCL, vs);
    endtask

    int burst_left = 0;

    task automatic send_request(logic [15:0] u, logic [15:0] v);
        i_screen_u <= u;
        i_screen_v <= v;
        start      <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (dir_queue.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int n);
        repeat (n) send_request(pick_coord(), pick_coord());
        drain();
    endtask

    t_row rows[$];

    initial begin
        fwd_axis   = 64'hC000 << 32;
        right_axis = 64'h4000;
        up_axis    = 64'h4000 << 16;
        h_scale    = SCALE_RST;
        v_scale    = SCALE_RST;
        rows = '{
            '{16'h8000, 16'h8000, 1'b1, '{16'sd0, 16'sd0, -16'sd16384}},
            '{16'h0000, 16'h0000, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
            '{16'hFFFF, 16'hFFFF, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
            '{16'h0000, 16'hFFFF, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
            '{16'hFFFF, 16'h0000, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
            '{16'h8000, 16'h0000, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
            '{16'h0000, 16'h8000, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
            '{16'h7FFF, 16'h8001, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
            '{16'h0001, 16'hFFFE, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
            '{16'h5555, 16'hAAAA, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
            '{16'hAAAA, 16'h5555, 1'b0, '{16'sd0, 16'sd0, 16'sd0}}
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            typed_flags.push_back(rows[k].typed);
            if (rows[k].typed) typed_queue.push_back(rows[k].dir);
            send_request(rows[k].u, rows[k].v);
        end
        drain();

        // zero forward and right/up: every ray, at any screen position, is a zero vector
        set_camera(64'h0, 64'h0, 64'h0, 64'h1000, 64'h1000);
        for (int k = 0; k < 4; k++) begin
            typed_flags.push_back(1'b1);
            typed_queue.push_back('{16'sd0, 16'sd0, 16'sd0});
            send_request(pick_coord(), pick_coord());
        end
        drain();

        cfg_write(BAD_IDX, 64'hFFFF_FFFF_FFFF_FFFF);
        set_camera(64'hC000 << 32, 64'h4000, 64'h4000 << 16,
                   64'hFFFF_0000_0000_1000, 64'h1234_5678_0000_1000);
        random_phase(250);

        set_camera(64'h0000_2D41_0000_D2BF, 64'h0000_2D41_0000_2D41,
                   64'h0000_0000_4000_0000, 64'h0000_FFFF, 64'h0000_FFFF);
        random_phase(250);

        set_camera(64'h0, 64'h0, 64'h0, 64'h0, 64'h0);
        random_phase(100);

        set_camera(64'hFFFF_8000_8000_8000, 64'h0000_7FFF_7FFF_7FFF,
                   64'h0000_8000_7FFF_8000, 64'h0000_FFFF, 64'h0000_0001);
        random_phase(250);

        for (int p = 0; p < 4; p++) begin
            set_camera({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom});
            random_phase(160);
        end

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
